### rtl/isma_pkg.sv
// Package for the integer stack machine ALU: opcodes, status codes,
// controller states and the control structs shared by the cell row and divider.
// No dependencies.
package isma_pkg;

   // Data word width of the stack and the arithmetic
   localparam int WORD_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 3;
   localparam int DEPTH_OUT_W = 7;

   // Opcodes (codes above OP_NOP act as nop)
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB = 3'd1;
   localparam logic [OP_W-1:0] OP_DIV = 3'd2;
   localparam logic [OP_W-1:0] OP_MOD = 3'd3;
   localparam logic [OP_W-1:0] OP_NOP = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SHORT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

   // Controller states
   typedef enum logic {
      CTL_IDLE,
      CTL_DIV
   } state_type;

   // Shift command to every cell of the stack row
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

   // Divider status back to the controller
   typedef struct packed {
      logic busy;
   } div_stat_type;

endpackage

### rtl/isma_cell.sv
// One stack cell: holds one word and shifts with its neighbors.
// Depends on isma_pkg (word width, cell control struct).
module isma_cell (
   input  logic                          clock,
   input  isma_pkg::cell_ctrl_type       ctrl,
   input  logic [isma_pkg::WORD_W-1:0]   push_data,
   input  logic [isma_pkg::WORD_W-1:0]   pop_data,
   output logic [isma_pkg::WORD_W-1:0]   value
);

   logic [isma_pkg::WORD_W-1:0] value_ff;
   logic [isma_pkg::WORD_W-1:0] value_in;

   // push takes the word from above, pop takes the word from below
   always_comb begin
      value_in = value_ff;
      if (ctrl.push) begin
         value_in = push_data;
      end else if (ctrl.pop) begin
         value_in = pop_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### rtl/isma_div.sv
// Signed 32-bit shift-subtract divider, one quotient bit per cycle.
// Truncates toward zero; remainder takes the dividend's sign. Depends on isma_pkg.
module isma_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [isma_pkg::WORD_W-1:0]   dividend,
   input  logic [isma_pkg::WORD_W-1:0]   divisor,
   output isma_pkg::div_stat_type        stat,
   output logic [isma_pkg::WORD_W-1:0]   quotient,
   output logic [isma_pkg::WORD_W-1:0]   remainder
);

   localparam int W = isma_pkg::WORD_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic             neg_q_ff, neg_q_in;
   logic             neg_r_ff, neg_r_in;
   logic [W:0]       shifted;
   logic [W+1:0]     diff;

   // one restoring step on the magnitudes
   always_comb begin
      shifted  = {rem_ff, quo_ff[W-1]};
      diff     = {1'b0, shifted} - {2'b00, den_ff};
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(W - 1);
         rem_in   = '0;
         quo_in   = dividend[W-1] ? (~dividend + W'(1)) : dividend;
         den_in   = divisor[W-1] ? (~divisor + W'(1)) : divisor;
         neg_q_in = dividend[W-1] ^ divisor[W-1];
         neg_r_in = dividend[W-1];
      end else if (busy_ff) begin
         if (!diff[W+1]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // sign fix-up of the finished magnitudes
   assign quotient  = neg_q_ff ? (~quo_ff + W'(1)) : quo_ff;
   assign remainder = neg_r_ff ? (~rem_ff + W'(1)) : rem_ff;
   assign stat.busy = busy_ff;

endmodule

### rtl/integer_stack_machine_alu_top.sv
// Integer stack machine ALU top level: controller, row of stack cells, divider.
// Depends on isma_pkg, isma_cell and isma_div.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_op, req_push_value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_top_value, rsp_depth
//
// Push, sub, nop and every error register their result at the accept edge.
// Div and mod: accept, 32 quotient steps in the divider, commit once the output is free.
// The stack is a row of cells: cell 0 is the top, the row shifts on push and pop.
// Reset clears the element count and the controller; cell contents are not cleared.
// A new item is taken while a result waits, unless the next commit would overwrite it.
module integer_stack_machine_alu_top #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [isma_pkg::OP_W-1:0]            req_op,
   input  logic signed [isma_pkg::WORD_W-1:0]   req_push_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [isma_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [isma_pkg::WORD_W-1:0]   rsp_top_value,
   output logic [isma_pkg::DEPTH_OUT_W-1:0]     rsp_depth
);

   localparam int W = isma_pkg::WORD_W;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   isma_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    is_mod_ff, is_mod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [isma_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [W-1:0]                     top_ff, top_in;
   logic [isma_pkg::DEPTH_OUT_W-1:0] depth_ff, depth_in;

   isma_pkg::cell_ctrl_type cell_ctrl;
   isma_pkg::div_stat_type  div_stat;
   logic [W-1:0]            cell_value [STACK_DEPTH];
   logic [W-1:0]            top_pop_data;
   logic [W-1:0]            div_quo, div_rem;
   logic                    div_start;
   logic                    out_free;
   logic                    accept;
   logic                    load;
   logic [W-1:0]            cur_top;
   logic [W-1:0]            sub_result;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != isma_pkg::CTL_IDLE) || !out_free;
   assign accept     = req_valid && !req_stall;
   assign cur_top    = (count_ff == '0) ? '0 : cell_value[0];
   assign sub_result = cell_value[1] - cell_value[0];

   // controller: decode, checks, cell commands and result register load
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      is_mod_in    = is_mod_ff;
      cell_ctrl    = '0;
      top_pop_data = sub_result;
      div_start    = 1'b0;
      load         = 1'b0;
      status_in    = isma_pkg::ST_OK;
      top_in       = cur_top;
      case (state_ff)
         isma_pkg::CTL_IDLE: begin
            if (accept) begin
               load = 1'b1;
               case (req_op)
                  isma_pkg::OP_PUSH: begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        status_in = isma_pkg::ST_FULL;
                     end else begin
                        cell_ctrl.push = 1'b1;
                        count_in       = count_ff + CNT_W'(1);
                        top_in         = req_push_value;
                     end
                  end
                  isma_pkg::OP_SUB, isma_pkg::OP_DIV, isma_pkg::OP_MOD: begin
                     if (count_ff == '0) begin
                        status_in = isma_pkg::ST_EMPTY;
                     end else if (count_ff == CNT_W'(1)) begin
                        status_in = isma_pkg::ST_SHORT;
                     end else if (req_op == isma_pkg::OP_SUB) begin
                        cell_ctrl.pop = 1'b1;
                        count_in      = count_ff - CNT_W'(1);
                        top_in        = sub_result;
                     end else if (cell_value[0] == '0) begin
                        status_in = isma_pkg::ST_DIVZERO;
                     end else begin
                        // hand the pair to the divider, result comes later
                        load      = 1'b0;
                        div_start = 1'b1;
                        is_mod_in = (req_op == isma_pkg::OP_MOD);
                        state_in  = isma_pkg::CTL_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         isma_pkg::CTL_DIV: begin
            top_pop_data = is_mod_ff ? div_rem : div_quo;
            if (!div_stat.busy && out_free) begin
               load          = 1'b1;
               cell_ctrl.pop = 1'b1;
               count_in      = count_ff - CNT_W'(1);
               top_in        = top_pop_data;
               state_in      = isma_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = isma_pkg::CTL_IDLE;
         end
      endcase
      depth_in = isma_pkg::DEPTH_OUT_W'(count_in);
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isma_pkg::CTL_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_mod_ff <= is_mod_in;
      if (load) begin
         status_ff <= status_in;
         top_ff    <= top_in;
         depth_ff  <= depth_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_top_value = top_ff;
   assign rsp_depth     = depth_ff;

   // row of stack cells, cell 0 is the top of stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [W-1:0] push_data;
      logic [W-1:0] pop_data;
      if (i == 0) begin : g_first
         assign push_data = req_push_value;
         assign pop_data  = top_pop_data;
      end else if (i == STACK_DEPTH - 1) begin : g_last
         assign push_data = cell_value[i-1];
         assign pop_data  = '0;
      end else begin : g_mid
         assign push_data = cell_value[i-1];
         assign pop_data  = cell_value[i+1];
      end
      isma_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .push_data (push_data),
         .pop_data  (pop_data),
         .value     (cell_value[i])
      );
   end

   // divider: dividend is the element below the top, divisor the top
   isma_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cell_value[1]),
      .divisor   (cell_value[0]),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // element count never passes the stack size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above stack size");

   // divider only runs while the controller waits on it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == isma_pkg::CTL_DIV)
      else $error("divider busy outside divide state");

   // the count moves only together with a result
   a_count_with_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && !load) |=> $stable(count_ff))
      else $error("stack count changed without a result");

   // an empty stack reports a zero top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_depth == '0) |-> rsp_top_value == '0)
      else $error("nonzero top on empty stack");

endmodule
